/* sv/wgcd_pkg.sv */
package wgcd_pkg;

  // Graph size and derived widths
  localparam int NODE_COUNT = 16;
  localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int SP_W       = $clog2(NODE_COUNT + 1);
  localparam int FIELD_W    = 4;

  typedef logic [NODE_COUNT-1:0] row_t;
  typedef logic [NODE_W-1:0]     node_t;
  typedef logic [SP_W-1:0]       sp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_WR,
    S_ROOT,
    S_SCAN,
    S_POP,
    S_DONE
  } state_e;

  // Adjacency memory access
  typedef struct packed {
    logic  rd_en;
    node_t rd_addr;
    logic  wr_en;
    node_t wr_addr;
    row_t  wr_data;
  } adj_req_t;

  // Search stack access
  typedef struct packed {
    logic  rd_en;
    node_t rd_addr;
    logic  wr_en;
    node_t wr_addr;
    node_t wr_data;
  } stk_req_t;

  // Index of the lowest set bit, zero when none is set
  function automatic node_t lowest_set(row_t vec);
    node_t idx;
    idx = '0;
    for (int i = NODE_COUNT - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = node_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

/* sv/wgcd_adj_mem.sv */
module wgcd_adj_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wgcd_pkg::adj_req_t req_i,
  output wgcd_pkg::row_t     rd_data_o
);
  import wgcd_pkg::*;

  row_t mem_q [NODE_COUNT];
  row_t row_vld_q;
  row_t rd_raw_q;
  logic rd_vld_q;

  // Rows never written read as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        row_vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[req_i.rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_raw_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_raw_q : '0;

endmodule

/* sv/wgcd_stack_mem.sv */
module wgcd_stack_mem (
  input  logic               clk_i,
  input  wgcd_pkg::stk_req_t req_i,
  output wgcd_pkg::node_t    rd_data_o
);
  import wgcd_pkg::*;

  node_t mem_q [NODE_COUNT];
  node_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

/* sv/wait_graph_cycle_detector_top.sv */
// Wait-for graph deadlock detector.
//
// Input channel (in_valid_i / in_ready_o): one request names a directed edge
// from_node_i -> to_node_i. The edge is OR-ed into the adjacency matrix; edges
// naming a node outside the graph are dropped, but the search still runs.
// Output channel (out_valid_o / out_ready_i): one result per request,
// cycle_found_o = 1 when the graph now holds a directed cycle (self-loop too).
//
// Operation: the source row is read on acceptance and written back in the
// next cycle; a depth-first search follows, one adjacency row read per cycle,
// spending time on each root tried, each search tree, each pushed node and
// each pop back to a parent; the single read port sets the pace. One request
// is in flight.
// A finished result sits in an output register, so the next request is taken
// while the receiver stalls; if the previous result is still unread when the
// search ends, the block holds in its done state until the slot frees.
// Reset empties the graph (per-row valid flags, no clearing pass) and leaves
// the block ready at once.
module wait_graph_cycle_detector_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [wgcd_pkg::FIELD_W-1:0]  from_node_i,
  input  logic [wgcd_pkg::FIELD_W-1:0]  to_node_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          cycle_found_o
);
  import wgcd_pkg::*;

  state_e state_q, state_d;

  logic [FIELD_W-1:0] from_q, from_d;
  logic [FIELD_W-1:0] to_q, to_d;
  row_t  visited_q, visited_d;
  row_t  on_path_q, on_path_d;
  node_t root_q, root_d;
  node_t top_q, top_d;
  sp_t   sp_q, sp_d;
  logic  found_q, found_d;
  logic  out_valid_q, out_valid_d;
  logic  cycle_q, cycle_d;

  adj_req_t adj_req;
  stk_req_t stk_req;
  row_t     adj_row;
  node_t    stk_node;

  logic  edge_ok;
  logic  root_last;
  logic  back_hit;
  row_t  fresh;
  node_t next_node;
  logic  out_free;

  wgcd_adj_mem u_adj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (adj_req),
    .rd_data_o(adj_row)
  );

  wgcd_stack_mem u_stack (
    .clk_i    (clk_i),
    .req_i    (stk_req),
    .rd_data_o(stk_node)
  );

  assign edge_ok   = (int'(from_q) < NODE_COUNT) && (int'(to_q) < NODE_COUNT);
  assign root_last = (root_q == node_t'(NODE_COUNT - 1));
  // Any edge into the current path closes a cycle
  assign back_hit  = |(adj_row & on_path_q);
  assign fresh     = adj_row & ~visited_q;
  assign next_node = lowest_set(fresh);
  assign out_free  = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EDGE_WR;
        end
      end
      S_EDGE_WR: state_d = S_ROOT;
      S_ROOT: begin
        if (!visited_q[root_q]) begin
          state_d = S_SCAN;
        end else if (root_last) begin
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        if (back_hit) begin
          state_d = S_DONE;
        end else if (fresh == '0) begin
          state_d = (sp_q > sp_t'(1)) ? S_POP : S_ROOT;
        end
      end
      S_POP: state_d = S_SCAN;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory requests
  always_comb begin
    from_d    = from_q;
    to_d      = to_q;
    visited_d = visited_q;
    on_path_d = on_path_q;
    root_d    = root_q;
    top_d     = top_q;
    sp_d      = sp_q;
    found_d   = found_q;
    adj_req   = '0;
    stk_req   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          from_d          = from_node_i;
          to_d            = to_node_i;
          adj_req.rd_en   = 1'b1;
          adj_req.rd_addr = node_t'(from_node_i);
        end
      end
      S_EDGE_WR: begin
        adj_req.wr_en   = edge_ok;
        adj_req.wr_addr = node_t'(from_q);
        adj_req.wr_data = adj_row | (row_t'(1) << node_t'(to_q));
        visited_d       = '0;
        on_path_d       = '0;
        root_d          = '0;
        sp_d            = '0;
        found_d         = 1'b0;
      end
      S_ROOT: begin
        if (!visited_q[root_q]) begin
          visited_d[root_q] = 1'b1;
          on_path_d[root_q] = 1'b1;
          stk_req.wr_en     = 1'b1;
          stk_req.wr_addr   = '0;
          stk_req.wr_data   = root_q;
          sp_d              = sp_t'(1);
          top_d             = root_q;
          adj_req.rd_en     = 1'b1;
          adj_req.rd_addr   = root_q;
        end else if (!root_last) begin
          root_d = root_q + node_t'(1);
        end
      end
      S_SCAN: begin
        if (back_hit) begin
          found_d = 1'b1;
        end else if (fresh != '0) begin
          visited_d[next_node] = 1'b1;
          on_path_d[next_node] = 1'b1;
          stk_req.wr_en        = 1'b1;
          stk_req.wr_addr      = sp_q[NODE_W-1:0];
          stk_req.wr_data      = next_node;
          sp_d                 = sp_q + sp_t'(1);
          top_d                = next_node;
          adj_req.rd_en        = 1'b1;
          adj_req.rd_addr      = next_node;
        end else begin
          on_path_d[top_q] = 1'b0;
          sp_d             = sp_q - sp_t'(1);
          if (sp_q > sp_t'(1)) begin
            stk_req.rd_en   = 1'b1;
            stk_req.rd_addr = node_t'(sp_q - sp_t'(2));
          end
        end
      end
      S_POP: begin
        top_d           = stk_node;
        adj_req.rd_en   = 1'b1;
        adj_req.rd_addr = stk_node;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    cycle_d     = cycle_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_DONE && out_free) begin
      out_valid_d = 1'b1;
      cycle_d     = found_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      visited_q   <= '0;
      on_path_q   <= '0;
      root_q      <= '0;
      sp_q        <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      visited_q   <= visited_d;
      on_path_q   <= on_path_d;
      root_q      <= root_d;
      sp_q        <= sp_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    from_q  <= from_d;
    to_q    <= to_d;
    top_q   <= top_d;
    cycle_q <= cycle_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign cycle_found_o = cycle_q;

  // Stack depth stays within the node count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(sp_q) <= NODE_COUNT)
    else $error("search stack overflow");

  // Nodes on the path are always visited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (on_path_q & ~visited_q) == '0)
    else $error("on-path node not marked visited");

  // Scanning needs a live stack top
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_POP) |-> (sp_q != '0))
    else $error("scan with empty stack");

  // A result only appears after the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result without finished search");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import wgcd_pkg::*;

  // A correct run never goes this long without a request or a result moving:
  // the long receiver hold-off plus a sender gap plus one full search.
  localparam int WATCHDOG_LIMIT = 5000;
  // Tail after the last result: longer than the slowest search.
  localparam int SETTLE_CYCLES  = 100;
  localparam int LONG_HOLD      = 800;
  localparam int MAX_PRINTED    = 100;

  typedef logic [FIELD_W-1:0] field_t;

  // Receiver back-pressure patterns
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_ready_o;
  field_t from_node_i = '0;
  field_t to_node_i   = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  logic   cycle_found_o;

  wait_graph_cycle_detector_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .from_node_i   (from_node_i),
    .to_node_i     (to_node_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cycle_found_o (cycle_found_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Wait-for graph mirror and deadlock flags still owed by the block
  // ---------------------------------------------------------------------------
  row_t wait_rows [NODE_COUNT] = '{default: '0};
  bit   deadlock_flag_q [$];
  int   mismatch_cnt = 0;

  // Random topological order: arcs from a lower to a higher position keep the
  // graph acyclic, so the search gets real work before the first deadlock.
  // Once a cycle exists it never goes away (edges are only ever added).
  int   topo_order [NODE_COUNT];

  function automatic void add_wait_arc(field_t src, field_t dst);
    if (int'(src) < NODE_COUNT && int'(dst) < NODE_COUNT) begin
      wait_rows[src][dst] = 1'b1;
    end
  endfunction

  // Peel off nodes with no arc into the remaining set; whatever cannot be
  // peeled sits on or leads only into a cycle. Self-loops never peel.
  function automatic bit graph_deadlocked();
    row_t live;
    bit   peeled;
    live = '1;
    do begin
      peeled = 1'b0;
      for (int n = 0; n < NODE_COUNT; n++) begin
        if (live[n] && ((wait_rows[n] & live) == '0)) begin
          live[n] = 1'b0;
          peeled  = 1'b1;
        end
      end
    end while (peeled);
    return (live != '0);
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTED) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of back-to-back requests separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  bit valid_held = 1'b0;

  task automatic send_request(int src, int dst);
    int gap;
    if (burst_left <= 0) begin
      // mostly short bursts, now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
    end
    from_node_i <= field_t'(src);
    to_node_i   <= field_t'(dst);
    in_valid_i  <= 1'b1;
    valid_held  = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    // accepted at this edge: update the mirror and predict
    add_wait_arc(field_t'(src), field_t'(dst));
    deadlock_flag_q.push_back(graph_deadlocked());
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
      // gaps up to beyond one search so they land on every phase of it
      gap = $urandom_range(1, 90);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Forward arc in the topological order; half of them short hops so that
  // long paths build up and the search goes deep.
  task automatic send_dag_arc();
    int lo;
    int hi;
    lo = $urandom_range(0, NODE_COUNT - 2);
    if ($urandom_range(0, 1) == 1) begin
      hi = lo + $urandom_range(1, 3);
      if (hi > NODE_COUNT - 1) hi = NODE_COUNT - 1;
    end else begin
      hi = $urandom_range(lo + 1, NODE_COUNT - 1);
    end
    send_request(topo_order[lo], topo_order[hi]);
  endtask

  task automatic wait_drained();
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
    end
    while (deadlock_flag_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: switches among stall patterns; a long hold-off on request
  // ---------------------------------------------------------------------------
  int          hold_off_req = 0;
  int          hold_left    = 0;
  int          mode_left    = 0;
  rx_mode_e    rx_mode      = RX_ALWAYS;
  logic [3:0]  rx_tick      = '0;

  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 4'd1;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_off_req > 0) begin
      hold_left    = hold_off_req - 1;
      hold_off_req = 0;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left = mode_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS:   out_ready_i <= 1'b1;
        RX_COIN:     out_ready_i <= ($urandom_range(0, 1) == 1);
        RX_SPARSE:   out_ready_i <= ($urandom_range(0, 7) == 0);
        default:     out_ready_i <= (rx_tick < 4'd5);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: every accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (deadlock_flag_q.size() == 0) begin
        report_mismatch($sformatf("result cycle_found=%b with no request pending",
                                  cycle_found_o));
      end else if (cycle_found_o !== deadlock_flag_q[0]) begin
        report_mismatch($sformatf("cycle_found=%b, model says %b",
                                  cycle_found_o, deadlock_flag_q[0]));
        void'(deadlock_flag_q.pop_front());
      end else begin
        void'(deadlock_flag_q.pop_front());
      end
    end
  end

  // Watchdog: too long with neither channel moving means the block hung
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty graph, field extremes, a repeated request, first arcs of the order
  task automatic test_first_edges();
    send_request(0, NODE_COUNT - 1);
    send_request(0, NODE_COUNT - 1);
    send_request(topo_order[0], topo_order[NODE_COUNT - 1]);
    send_request(topo_order[NODE_COUNT - 2], topo_order[NODE_COUNT - 1]);
    send_request(topo_order[0], topo_order[1]);
    wait_drained();
  endtask

  task automatic test_random_dag(int count);
    for (int k = 0; k < count; k++) begin
      send_dag_arc();
    end
    wait_drained();
  endtask

  // Path through every node: the graph then holds a path of full length
  task automatic test_deep_chain();
    for (int k = 0; k < NODE_COUNT - 1; k++) begin
      send_request(topo_order[k], topo_order[k + 1]);
    end
    wait_drained();
  endtask

  // Receiver holds off while requests keep coming: the output slot fills,
  // the next search parks in its done state and the input stalls
  task automatic test_stall_pressure();
    hold_off_req = LONG_HOLD;
    burst_left   = 20;
    for (int k = 0; k < 12; k++) begin
      send_dag_arc();
    end
    wait_drained();
  endtask

  // Back arc closing a cycle through all nodes, then self-loops and extremes
  task automatic test_cycle_closure();
    send_request(topo_order[NODE_COUNT - 1], topo_order[0]);
    send_request(NODE_COUNT - 1, 0);
    send_request(0, NODE_COUNT - 1);
    send_request(0, 0);
    send_request(NODE_COUNT - 1, NODE_COUNT - 1);
    wait_drained();
  endtask

  task automatic test_random_after_cycle(int count);
    for (int k = 0; k < count; k++) begin
      send_request($urandom_range(0, NODE_COUNT - 1), $urandom_range(0, NODE_COUNT - 1));
    end
    wait_drained();
  endtask

  initial begin
    int pick;
    int tmp;
    int pos_first;
    int pos_last;

    for (int k = 0; k < NODE_COUNT; k++) topo_order[k] = k;
    for (int k = NODE_COUNT - 1; k > 0; k--) begin
      pick             = $urandom_range(0, k);
      tmp              = topo_order[k];
      topo_order[k]    = topo_order[pick];
      topo_order[pick] = tmp;
    end
    // node 0 ahead of the last node, so 0 -> last is legal while acyclic
    pos_first = 0;
    pos_last  = 0;
    for (int k = 0; k < NODE_COUNT; k++) begin
      if (topo_order[k] == 0) pos_first = k;
      if (topo_order[k] == NODE_COUNT - 1) pos_last = k;
    end
    if (pos_first > pos_last) begin
      topo_order[pos_first] = NODE_COUNT - 1;
      topo_order[pos_last]  = 0;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_first_edges();
    test_random_dag(700);
    test_deep_chain();
    test_stall_pressure();
    test_random_dag(600);
    test_cycle_closure();
    test_random_after_cycle(150);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0 && deadlock_flag_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* wait_graph_cycle_detector_top.f */
sv/wgcd_pkg.sv
sv/wgcd_adj_mem.sv
sv/wgcd_stack_mem.sv
sv/wait_graph_cycle_detector_top.sv
tb/sv/tb.sv
